[design/bba_pkg.sv]
// shared types, constants and layout helpers for the buddy block allocator
// no dependencies; imported by every module of the block
package bba_pkg;

    localparam int MIN_ORDER    = 4;
    localparam int TOP_ORDER    = 12;
    localparam int ARENA_BLOCKS = 4;

    localparam int ADDR_W  = 14;
    localparam int SIZE_W  = 16;
    localparam int ST_W    = 2;
    localparam int ROW_W   = 32;
    localparam int BIT_W   = $clog2(ROW_W);
    localparam int ORD_W   = $clog2(TOP_ORDER + 2);
    localparam int FRESH_W = $clog2(ARENA_BLOCKS + 1);

    // rows of ROW_W map bits per order, packed order after order
    function automatic int blocks_at(int k);
        return ARENA_BLOCKS << (TOP_ORDER - k);
    endfunction

    function automatic int rows_at(int k);
        return (blocks_at(k) + ROW_W - 1) / ROW_W;
    endfunction

    function automatic int base_row(int k);
        int b;
        b = 0;
        for (int j = MIN_ORDER; j < k; j++) begin
            b += rows_at(j);
        end
        return b;
    endfunction

    localparam int NROWS = base_row(TOP_ORDER + 1);
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int MAXR  = rows_at(MIN_ORDER);
    localparam int JW    = (MAXR > 1) ? $clog2(MAXR) : 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_BIG  = 2'd2;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd3;

    // which map bit an access goes to
    localparam logic [1:0] TS_FOUND      = 2'd0;
    localparam logic [1:0] TS_SPLIT_NEXT = 2'd1;
    localparam logic [1:0] TS_BUDDY      = 2'd2;
    localparam logic [1:0] TS_SELF       = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       wr;
        logic [1:0] tsel;
        logic       set_bit;
        logic       ord_inc;
        logic       ord_dec;
        logic       take_fresh;
        logic       take_found;
        logic       merge;
        logic       set_oom;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic pre_bad;
        logic is_free;
        logic ord_hit;
        logic cur_top;
        logic cur_want;
        logic fresh_ok;
        logic rbit;
        logic out_busy;
    } sts_t;

endpackage

[design/bba_ctrl.sv]
// sequencer for allocate search/split and free merge
// depends on bba_pkg
module bba_ctrl import bba_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SEARCH   = 4'd2;
    localparam logic [3:0] S_FOUND    = 4'd3;
    localparam logic [3:0] S_SPLIT_RD = 4'd4;
    localparam logic [3:0] S_SPLIT_WR = 4'd5;
    localparam logic [3:0] S_MRG_RD   = 4'd6;
    localparam logic [3:0] S_MRG_CHK  = 4'd7;
    localparam logic [3:0] S_SET_WR   = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.pre_bad) state_next = S_FINISH;
                else if (sts.is_free) state_next = S_MRG_RD;
                else state_next = S_SEARCH;
            end
            S_SEARCH: begin
                if (sts.ord_hit) begin
                    cmd.rd     = 1'b1;
                    cmd.tsel   = TS_FOUND;
                    state_next = S_FOUND;
                end else if (sts.cur_top) begin
                    if (sts.fresh_ok) begin
                        cmd.take_fresh = 1'b1;
                        state_next     = S_SPLIT_RD;
                    end else begin
                        cmd.set_oom = 1'b1;
                        state_next  = S_FINISH;
                    end
                end else begin
                    cmd.ord_inc = 1'b1;
                end
            end
            S_FOUND: begin
                cmd.wr         = 1'b1;
                cmd.tsel       = TS_FOUND;
                cmd.take_found = 1'b1;
                state_next     = S_SPLIT_RD;
            end
            S_SPLIT_RD: begin
                if (sts.cur_want) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.rd      = 1'b1;
                    cmd.tsel    = TS_SPLIT_NEXT;
                    cmd.ord_dec = 1'b1;
                    state_next  = S_SPLIT_WR;
                end
            end
            S_SPLIT_WR: begin
                // order already stepped down, so the upper half is the buddy of addr
                cmd.wr      = 1'b1;
                cmd.tsel    = TS_BUDDY;
                cmd.set_bit = 1'b1;
                state_next  = S_SPLIT_RD;
            end
            S_MRG_RD: begin
                cmd.rd = 1'b1;
                if (sts.cur_top) begin
                    cmd.tsel   = TS_SELF;
                    state_next = S_SET_WR;
                end else begin
                    cmd.tsel   = TS_BUDDY;
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK: begin
                if (sts.rbit) begin
                    cmd.wr     = 1'b1;
                    cmd.tsel   = TS_BUDDY;
                    cmd.merge  = 1'b1;
                    state_next = S_MRG_RD;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.tsel   = TS_SELF;
                    state_next = S_SET_WR;
                end
            end
            S_SET_WR: begin
                cmd.wr      = 1'b1;
                cmd.tsel    = TS_SELF;
                cmd.set_bit = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/bba_dpath.sv]
// free map memory with row occupancy flags, order/address registers, result register
// depends on bba_pkg; driven by bba_ctrl commands
module bba_dpath import bba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  in_op,
    input  logic [SIZE_W-1:0]     in_size,
    input  logic [ADDR_W-1:0]     in_faddr,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ADDR_W-1:0]     out_addr,
    output logic [ST_W-1:0]       out_status
);

    logic [ROW_W-1:0]  mem [NROWS];
    logic [NROWS-1:0]  flag_reg;
    logic [ROW_W-1:0]  rdata_reg;
    logic              rd_vld_reg;
    logic [RW-1:0]     rd_row_reg;
    logic              op_reg;
    logic [ST_W-1:0]   st_reg;
    logic [ORD_W-1:0]  cur_reg, want_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [FRESH_W-1:0] fresh_reg;
    logic              ovld_reg;
    logic [ADDR_W-1:0] oaddr_reg;
    logic [ST_W-1:0]   ost_reg;

    function automatic logic [RW-1:0] base_of(logic [ORD_W-1:0] o);
        logic [RW-1:0] b;
        b = '0;
        for (int k = MIN_ORDER; k <= TOP_ORDER; k++) begin
            if (o == ORD_W'(k)) b = RW'(base_row(k));
        end
        return b;
    endfunction

    // ceiling log2 of the size, clamped to the minimum order
    logic [ORD_W-1:0]  k_c;
    logic [SIZE_W-1:0] szm1;
    logic [ST_W-1:0]   pre_st;
    always_comb begin
        szm1 = in_size - SIZE_W'(1);
        k_c  = ORD_W'(MIN_ORDER);
        for (int b = 0; b < SIZE_W; b++) begin
            if (szm1[b] && (b + 1 > MIN_ORDER)) k_c = ORD_W'(b + 1);
        end
        if (in_size == '0) pre_st = ST_ZERO;
        else if ({16'd0, in_size} > (32'd1 << TOP_ORDER)) pre_st = ST_BIG;
        else if (in_op == OP_FREE &&
                 {18'd0, in_faddr} >= (32'(ARENA_BLOCKS) << TOP_ORDER)) pre_st = ST_OOM;
        else pre_st = ST_OK;
    end

    // lowest occupied row of the current order
    logic [RW-1:0] cbase;
    logic [JW:0]   crows;
    logic          hit;
    logic [JW-1:0] hit_j;
    always_comb begin
        cbase = '0;
        crows = '0;
        for (int k = MIN_ORDER; k <= TOP_ORDER; k++) begin
            if (cur_reg == ORD_W'(k)) begin
                cbase = RW'(base_row(k));
                crows = (JW + 1)'(rows_at(k));
            end
        end
        hit   = 1'b0;
        hit_j = '0;
        for (int j = MAXR - 1; j >= 0; j--) begin
            if ((JW + 1)'(j) < crows && (int'(cbase) + j) < NROWS) begin
                if (flag_reg[int'(cbase) + j]) begin
                    hit   = 1'b1;
                    hit_j = JW'(j);
                end
            end
        end
    end

    logic [ROW_W-1:0] rdata_eff;
    assign rdata_eff = rd_vld_reg ? rdata_reg : '0;

    // lowest free bit of the row read for a found block
    logic [BIT_W-1:0] low_bit;
    always_comb begin
        low_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (rdata_eff[b]) low_bit = BIT_W'(b);
        end
    end

    // target map bit
    logic [ORD_W-1:0]  t_ord;
    logic [ADDR_W-1:0] t_addr, t_n;
    logic [RW-1:0]     t_row;
    logic [BIT_W-1:0]  t_bit;
    always_comb begin
        case (cmd.tsel)
            TS_SPLIT_NEXT: begin
                t_ord  = cur_reg - ORD_W'(1);
                t_addr = addr_reg | (ADDR_W'(1) << t_ord);
            end
            TS_BUDDY: begin
                t_ord  = cur_reg;
                t_addr = addr_reg ^ (ADDR_W'(1) << cur_reg);
            end
            default: begin
                t_ord  = cur_reg;
                t_addr = addr_reg;
            end
        endcase
        t_n   = t_addr >> t_ord;
        t_row = base_of(t_ord) + RW'(t_n >> BIT_W);
        t_bit = t_n[BIT_W-1:0];
        if (cmd.tsel == TS_FOUND) begin
            t_row = cbase + RW'(hit_j);
            t_bit = low_bit;
        end
    end

    // buddy bit position, independent of the command so the merge check has no loop
    logic [ADDR_W-1:0] b_n;
    assign b_n = (addr_reg ^ (ADDR_W'(1) << cur_reg)) >> cur_reg;

    logic [ROW_W-1:0] wdata;
    always_comb begin
        wdata = rdata_eff;
        wdata[t_bit] = cmd.set_bit;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) mem[rd_row_reg] <= wdata;
        if (cmd.rd) begin
            rdata_reg  <= mem[t_row];
            rd_row_reg <= t_row;
        end
    end

    logic [ADDR_W-1:0] found_n;
    assign found_n = (ADDR_W'(rd_row_reg - cbase) << BIT_W) | ADDR_W'(low_bit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= '0;
            rd_vld_reg <= 1'b0;
            fresh_reg  <= '0;
            ovld_reg   <= 1'b0;
        end else begin
            if (cmd.rd) rd_vld_reg <= flag_reg[t_row];
            if (cmd.wr) flag_reg[rd_row_reg] <= (wdata != '0);
            if (cmd.take_fresh) fresh_reg <= fresh_reg + FRESH_W'(1);
            if (cmd.fin) ovld_reg <= 1'b1;
            else if (m_tready) ovld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            st_reg   <= pre_st;
            cur_reg  <= k_c;
            want_reg <= k_c;
            addr_reg <= in_faddr & ~((ADDR_W'(1) << k_c) - ADDR_W'(1));
        end
        if (cmd.ord_inc) cur_reg <= cur_reg + ORD_W'(1);
        if (cmd.ord_dec) cur_reg <= cur_reg - ORD_W'(1);
        if (cmd.take_fresh) begin
            addr_reg <= ADDR_W'(fresh_reg) << TOP_ORDER;
            cur_reg  <= ORD_W'(TOP_ORDER);
        end
        if (cmd.take_found) addr_reg <= found_n << cur_reg;
        if (cmd.merge) begin
            addr_reg <= addr_reg & ~(ADDR_W'(1) << cur_reg);
            cur_reg  <= cur_reg + ORD_W'(1);
        end
        if (cmd.set_oom) st_reg <= ST_OOM;
        if (cmd.fin) begin
            ost_reg   <= st_reg;
            oaddr_reg <= (op_reg == OP_ALLOC && st_reg == ST_OK) ? addr_reg : '0;
        end
    end

    assign sts.pre_bad  = (st_reg != ST_OK);
    assign sts.is_free  = (op_reg == OP_FREE);
    assign sts.ord_hit  = hit;
    assign sts.cur_top  = (cur_reg == ORD_W'(TOP_ORDER));
    assign sts.cur_want = (cur_reg == want_reg);
    assign sts.fresh_ok = (fresh_reg < FRESH_W'(ARENA_BLOCKS));
    assign sts.rbit     = rdata_eff[b_n[BIT_W-1:0]];
    assign sts.out_busy = ovld_reg && !m_tready;

    assign m_tvalid   = ovld_reg;
    assign out_addr   = oaddr_reg;
    assign out_status = ost_reg;

`ifndef SYNTH
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= FRESH_W'(ARENA_BLOCKS))
        else $error("fresh block count past arena");
    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd && cmd.wr))
        else $error("map read and write in one cycle");
    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> $past(cmd.rd))
        else $error("map write without preceding read");
    a_fin_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovld_reg && !m_tready) |=> $stable(oaddr_reg) && $stable(ost_reg))
        else $error("result changed while stalled");
`endif

endmodule

[design/buddy_block_allocator_unit.sv]
// channel  dir  tdata (low bit up)                       tuser
// s_       in   req_size[15:0] free_addr[29:16] pad     opcode[0]
// m_       out  block_addr[13:0] status[15:14]           -
// one item at a time: an alloc searches order by order, then reads and writes the map once
// per split level; a free reads the buddy bit and clears it per merge level, then sets its
// own bit; rejected words go straight to finish; the single-port free map sets this pacing
// reset clears the row flags at once, so no clearing pass is needed
// a finished result waits in the output register; the next word is taken then
// top level of the buddy block allocator; depends on bba_pkg, bba_ctrl, bba_dpath
module buddy_block_allocator_unit import bba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size, free_addr
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // block_addr, status
);

    cmd_t              cmd;
    sts_t              sts;
    logic [ADDR_W-1:0] out_addr;
    logic [ST_W-1:0]   out_status;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser[0]),
        .in_size    (s_tdata[15:0]),
        .in_faddr   (s_tdata[29:16]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_addr   (out_addr),
        .out_status (out_status)
    );

    assign m_tdata = {out_status, out_addr};

endmodule
